### rtl/gsac_pkg.sv
`default_nettype none

package gsac_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_ARGB = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_ARGB = 4'd3;

    // glyph modes
    localparam logic [1:0] MODE_SUPERSAMPLE = 2'd0;
    localparam logic [1:0] MODE_EDGE = 2'd1;
    localparam logic [1:0] MODE_FILL = 2'd2;
    localparam logic [1:0] MODE_OFF = 2'd3;

    // register reset values
    localparam logic [1:0] GLYPH_MODE_RST = MODE_FILL;
    localparam logic [3:0] QUALITY_RST = 4'd1;
    localparam logic [31:0] EDGE_ARGB_RST = 32'hff00_0000;
    localparam logic [31:0] FILL_ARGB_RST = 32'hffff_ffff;

    typedef struct packed {
        logic [7:0] bg_level;
        logic [7:0] edge_level;
        logic [7:0] fill_level;
    } gsac_in_t;

    typedef struct packed {
        logic [7:0] out_alpha;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } gsac_out_t;

    typedef struct packed {
        logic acc_en;       // add the accepted sample into the open cell
        logic div_start;    // close the cell and load the dividers
        logic div_step;     // one restoring division step
        logic out_load;     // write the output register
        logic out_sel_div;  // compose from the quotients, not the input sample
    } gsac_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       cell_done;
        logic       out_free;
    } gsac_stat_t;

endpackage

`default_nettype wire

### rtl/gsac_ctrl.sv
`default_nettype none

module gsac_ctrl
    import gsac_pkg::*;
#(
    parameter int MAX_QUALITY = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire gsac_stat_t stat,
    output gsac_cmd_t       cmd
);

    localparam int SUM_W = $clog2(MAX_QUALITY * MAX_QUALITY * 255 + 1);
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        in_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.mode inside {MODE_EDGE, MODE_FILL})
                begin
                    in_ready = stat.out_free;
                    if (in_valid && in_ready)
                    begin
                        cmd.out_load = 1'b1;
                    end
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid && in_ready && stat.mode == MODE_SUPERSAMPLE)
                    begin
                        cmd.acc_en = 1'b1;
                        if (stat.cell_done)
                        begin
                            cmd.div_start = 1'b1;
                            step_next = '0;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.out_sel_div = 1'b1;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gsac_datapath.sv
`default_nettype none

module gsac_datapath
    import gsac_pkg::*;
#(
    parameter int MAX_QUALITY = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire gsac_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output gsac_out_t                  out_data,
    input  wire gsac_cmd_t             cmd,
    output gsac_stat_t                 stat
);

    localparam int SUM_W = $clog2(MAX_QUALITY * MAX_QUALITY * 255 + 1);
    localparam int CNT_W = $clog2(MAX_QUALITY * MAX_QUALITY + 1);
    localparam int Q_W = $clog2(MAX_QUALITY + 1);

    logic [1:0]  mode_reg;
    logic [3:0]  quality_reg;
    logic [31:0] edge_argb_reg;
    logic [31:0] fill_argb_reg;

    logic [SUM_W-1:0] sum_reg [3];
    logic [SUM_W-1:0] quot_reg [3];
    logic [CNT_W-1:0] rem_reg [3];
    logic [CNT_W-1:0] cnt_reg;

    logic [SUM_W-1:0] sum_add [3];
    logic [SUM_W-1:0] quot_next [3];
    logic [CNT_W-1:0] rem_next [3];
    logic [7:0]       level [3];

    logic [Q_W-1:0]   q_eff;
    logic [CNT_W-1:0] q_ext;
    logic [CNT_W-1:0] q2;
    logic [CNT_W-1:0] cnt_plus;
    logic             cfg_xfer;
    logic             cell_clr;

    logic             out_valid_reg;
    gsac_out_t        out_data_reg;
    gsac_out_t        composed;
    logic [7:0]       c_bg, c_ed, c_fl;

    function automatic gsac_out_t compose(
        input logic [1:0]  mode,
        input logic [7:0]  bg,
        input logic [7:0]  ed,
        input logic [7:0]  fl,
        input logic [31:0] ec,
        input logic [31:0] fc
    );
        logic [31:0] word;
        logic [15:0] pe, pf, pa;
        logic [8:0]  s;
        begin
            word = '0;
            if (mode == MODE_FILL)
            begin
                pa = {8'd0, 8'hff - bg} * {8'd0, fc[31:24]};
                word = {pa[15:8], fc[23:0]};
            end
            else if (bg != 8'd0)
            begin
                pa = {8'd0, 8'hff - bg} * {8'd0, ec[31:24]};
                word = {pa[15:8], ec[23:0]};
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    pe = {8'd0, ec[8*k +: 8]} * {8'd0, ed};
                    pf = {8'd0, fc[8*k +: 8]} * {8'd0, fl};
                    s = {1'b0, pe[15:8]} + {1'b0, pf[15:8]};
                    word[8*k +: 8] = s[8] ? 8'hff : s[7:0];
                end
            end
            return gsac_out_t'(word);
        end
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign cell_clr = cfg_xfer && (cfg_index inside {REG_GLYPH_MODE, REG_QUALITY});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= GLYPH_MODE_RST;
            quality_reg <= QUALITY_RST;
            edge_argb_reg <= EDGE_ARGB_RST;
            fill_argb_reg <= FILL_ARGB_RST;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                REG_GLYPH_MODE: mode_reg <= cfg_data[1:0];
                REG_QUALITY:    quality_reg <= cfg_data[3:0];
                REG_EDGE_ARGB:  edge_argb_reg <= cfg_data;
                REG_FILL_ARGB:  fill_argb_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // clamp quality to 1..MAX_QUALITY
    always_comb
    begin
        if (quality_reg == 4'd0)
        begin
            q_eff = Q_W'(1);
        end
        else if (int'(quality_reg) > MAX_QUALITY)
        begin
            q_eff = Q_W'(MAX_QUALITY);
        end
        else
        begin
            q_eff = Q_W'(quality_reg);
        end
    end

    assign q_ext = CNT_W'(q_eff);
    assign q2 = q_ext * q_ext;
    assign cnt_plus = cnt_reg + 1'b1;

    assign level[0] = in_data.bg_level;
    assign level[1] = in_data.edge_level;
    assign level[2] = in_data.fill_level;

    // cell accumulators and one restoring divider per coverage
    always_comb
    begin
        logic [CNT_W:0] trial;
        for (int i = 0; i < 3; i++)
        begin
            sum_add[i] = sum_reg[i] + SUM_W'(level[i]);
            trial = {rem_reg[i], quot_reg[i][SUM_W-1]};
            if (trial >= {1'b0, q2})
            begin
                rem_next[i] = CNT_W'(trial - {1'b0, q2});
                quot_next[i] = {quot_reg[i][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[CNT_W-1:0];
                quot_next[i] = {quot_reg[i][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (cell_clr || cmd.div_start)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (cmd.acc_en)
        begin
            cnt_reg <= cnt_plus;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= sum_add[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.div_start)
            begin
                quot_reg[i] <= sum_add[i];
                rem_reg[i] <= '0;
            end
            else if (cmd.div_step)
            begin
                quot_reg[i] <= quot_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    // composition source: quotients after a cell, else the sample itself
    assign c_bg = cmd.out_sel_div ? quot_reg[0][7:0] : in_data.bg_level;
    assign c_ed = cmd.out_sel_div ? quot_reg[1][7:0] : in_data.edge_level;
    assign c_fl = cmd.out_sel_div ? quot_reg[2][7:0] : in_data.fill_level;
    assign composed = compose(mode_reg, c_bg, c_ed, c_fl, edge_argb_reg, fill_argb_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= composed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign stat.mode = mode_reg;
    assign stat.cell_done = (cnt_plus >= q2);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

### rtl/glyph_supersample_argb_composer.sv
// Result: modes 1 and 2 load the output register on the sample transfer; mode 0, the
//   closing sample of a cell loads it after the 14-step restoring division.
// Throughput: modes 1 and 2 one sample per cycle unless the output stalls; mode 0
//   one sample per cycle inside a cell, busy from cell close to result load.
// Reset: asynchronous, active low; registers return to mode 2, quality 1, opaque
//   black edge, opaque white fill, cell accumulators and output valid cleared.
`default_nettype none

module glyph_supersample_argb_composer
    import gsac_pkg::*;
#(
    parameter int MAX_QUALITY = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire gsac_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output gsac_out_t                  out_data
);

    // Controller sequences sample transfers, the per-cell division loop and the
    // output register load; datapath holds registers, sums, dividers, composer.
    gsac_cmd_t  cmd;
    gsac_stat_t stat;

    gsac_ctrl #(
        .MAX_QUALITY(MAX_QUALITY)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsac_datapath #(
        .MAX_QUALITY(MAX_QUALITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef ASSERT_OFF
    // never overwrite a result that has not been transferred
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register loaded while a result is pending");

    // a cell closes only in supersampled mode
    a_div_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (stat.mode == MODE_SUPERSAMPLE))
        else $error("division started outside supersampled mode");

    // no sample transfer while the division loop runs
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ready)
        else $error("input ready during division");

    // a closed cell starts the division loop on the next cycle
    a_div_follow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> cmd.div_step)
        else $error("division did not run after cell close");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench
    import gsac_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_QUALITY = 8;
    // Wait for the division loop of a cell's closing sample, with margin on top.
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS = 550;
    localparam int MAX_REPORTS = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    gsac_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    gsac_out_t             out_data;

    glyph_supersample_argb_composer #(
        .MAX_QUALITY(MAX_QUALITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // Pixel predictor: mirrors the register file and the open cell, and keeps the
    // pixels that the block still owes us, oldest first.
    class glyph_pixel_scoreboard;
        logic [1:0]  mode_reg;
        logic [3:0]  quality_reg;
        logic [31:0] edge_argb;
        logic [31:0] fill_argb;
        int unsigned bg_sum;
        int unsigned edge_sum;
        int unsigned fill_sum;
        int unsigned cell_count;
        gsac_out_t   owed_pixels[$];
        int          mismatches;

        function new();
            mode_reg = GLYPH_MODE_RST;
            quality_reg = QUALITY_RST;
            edge_argb = EDGE_ARGB_RST;
            fill_argb = FILL_ARGB_RST;
            mismatches = 0;
            clear_cell();
        endfunction

        function void clear_cell();
            bg_sum = 0;
            edge_sum = 0;
            fill_sum = 0;
            cell_count = 0;
        endfunction

        // Samples per cell: quality zero acts as one, quality above the maximum saturates.
        function int unsigned cell_size();
            int unsigned q;
            q = 32'(quality_reg);
            if (q == 0)
                q = 1;
            if (q > MAX_QUALITY)
                q = MAX_QUALITY;
            return q * q;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_GLYPH_MODE:
                begin
                    mode_reg = data[1:0];
                    clear_cell();
                end
                REG_QUALITY:
                begin
                    quality_reg = data[3:0];
                    clear_cell();
                end
                REG_EDGE_ARGB: edge_argb = data;
                REG_FILL_ARGB: fill_argb = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] mix_channel(logic [7:0] e, logic [7:0] f, int unsigned ed,
                                         int unsigned fl);
            int unsigned v;
            v = ((e * ed) >> 8) + ((f * fl) >> 8);
            return (v > 255) ? 8'hff : v[7:0];
        endfunction

        function gsac_out_t edge_pixel(int unsigned bg, int unsigned ed, int unsigned fl);
            gsac_out_t p;
            int unsigned a;
            if (bg != 0)
            begin
                a = ((255 - bg) * edge_argb[31:24]) >> 8;
                p.out_alpha = a[7:0];
                p.out_red = edge_argb[23:16];
                p.out_green = edge_argb[15:8];
                p.out_blue = edge_argb[7:0];
            end
            else
            begin
                p.out_alpha = mix_channel(edge_argb[31:24], fill_argb[31:24], ed, fl);
                p.out_red = mix_channel(edge_argb[23:16], fill_argb[23:16], ed, fl);
                p.out_green = mix_channel(edge_argb[15:8], fill_argb[15:8], ed, fl);
                p.out_blue = mix_channel(edge_argb[7:0], fill_argb[7:0], ed, fl);
            end
            return p;
        endfunction

        function void take_sample(gsac_in_t s);
            gsac_out_t p;
            int unsigned a;
            int unsigned n;
            case (mode_reg)
                MODE_SUPERSAMPLE:
                begin
                    n = cell_size();
                    bg_sum += 32'(s.bg_level);
                    edge_sum += 32'(s.edge_level);
                    fill_sum += 32'(s.fill_level);
                    cell_count++;
                    if (cell_count >= n)
                    begin
                        owed_pixels.push_back(edge_pixel(bg_sum / n, edge_sum / n,
                                                         fill_sum / n));
                        clear_cell();
                    end
                end
                MODE_EDGE:
                    owed_pixels.push_back(edge_pixel(32'(s.bg_level), 32'(s.edge_level),
                                                     32'(s.fill_level)));
                MODE_FILL:
                begin
                    a = ((255 - 32'(s.bg_level)) * fill_argb[31:24]) >> 8;
                    p.out_alpha = a[7:0];
                    p.out_red = fill_argb[23:16];
                    p.out_green = fill_argb[15:8];
                    p.out_blue = fill_argb[7:0];
                    owed_pixels.push_back(p);
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(gsac_out_t got);
            gsac_out_t want;
            if (owed_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected pixel a=%h r=%h g=%h b=%h", $realtime,
                             got.out_alpha, got.out_red, got.out_green, got.out_blue);
                return;
            end
            want = owed_pixels.pop_front();
            if (got.out_alpha !== want.out_alpha || got.out_red !== want.out_red ||
                got.out_green !== want.out_green || got.out_blue !== want.out_blue)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: pixel mismatch, expected a=%h r=%h g=%h b=%h, got a=%h r=%h g=%h b=%h",
                             $realtime, want.out_alpha, want.out_red, want.out_green,
                             want.out_blue, got.out_alpha, got.out_red, got.out_green,
                             got.out_blue);
            end
        endfunction
    endclass

    glyph_pixel_scoreboard sb = new();

    // Samples left in the current burst before the sender takes a break.
    int burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #400_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Receiver: check every pixel transfer against the oldest owed pixel, and
    // change the stall style at random (always ready, coin flip, sparse ready,
    // mostly ready).
    initial
    begin
        int style;
        int style_left;
        style = 0;
        style_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
                sb.check_pixel(out_data);
            if (style_left == 0)
            begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 120);
            end
            style_left--;
            case (style)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Offer one sample and hold it until the transfer. Keep valid high while the
    // burst lasts; at the end of a burst drop valid for a random gap.
    task automatic send_sample(input gsac_in_t s);
        in_valid <= 1'b1;
        in_data <= s;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.take_sample(s);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Hold the register write until the transfer; valid stays high for the next
    // write, end_register_writes drops it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_register(idx, data);
    endtask

    task automatic end_register_writes();
        cfg_valid <= 1'b0;
    endtask

    // Drop the sample stream, wait for every owed pixel, then give a cell whose
    // division may still be running (or a sample that owes nothing) time to finish.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (sb.owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [3:0] q,
                             input logic [31:0] ec, input logic [31:0] fc);
        logic [31:0] d;
        settle_block();
        // Upper data bits are don't-care for the narrow registers: fill them randomly.
        d = $urandom;
        d[1:0] = mode;
        write_register(REG_GLYPH_MODE, d);
        d = $urandom;
        d[3:0] = q;
        write_register(REG_QUALITY, d);
        write_register(REG_EDGE_ARGB, ec);
        write_register(REG_FILL_ARGB, fc);
        if ($urandom_range(0, 5) == 0)
            write_register(CFG_IDX_W'($urandom_range(REG_FILL_ARGB + 1,
                                                     (1 << CFG_IDX_W) - 1)), $urandom);
        end_register_writes();
    endtask

    // Bias coverage bytes toward the extremes.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // A zero background selects the edge/fill blend, so ask for it explicitly.
    function automatic gsac_in_t make_sample(input bit clear_bg);
        gsac_in_t s;
        s.bg_level = clear_bg ? 8'h00 : pick_level();
        s.edge_level = pick_level();
        s.fill_level = pick_level();
        return s;
    endfunction

    initial
    begin
        logic [1:0]  mode;
        logic [3:0]  q;
        int          counted;
        int          round;
        int          r;
        int          cells;
        int unsigned n;
        bit          clear_bg;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: fill only, opaque white fill; sweep the background level.
        send_sample('{bg_level: 8'h00, edge_level: 8'hff, fill_level: 8'hff});
        send_sample('{bg_level: 8'hff, edge_level: 8'h00, fill_level: 8'h00});
        send_sample('{bg_level: 8'h80, edge_level: 8'h55, fill_level: 8'haa});

        // Plain edge mode with white colors: full coverage saturates every channel.
        settle_block();
        write_register(REG_EDGE_ARGB, 32'hffff_ffff);
        write_register(REG_FILL_ARGB, 32'hffff_ffff);
        write_register(REG_GLYPH_MODE, {30'd0, MODE_EDGE});
        end_register_writes();
        send_sample('{bg_level: 8'h00, edge_level: 8'hff, fill_level: 8'hff});
        send_sample('{bg_level: 8'h00, edge_level: 8'h00, fill_level: 8'h00});
        send_sample('{bg_level: 8'h01, edge_level: 8'h12, fill_level: 8'h34});
        send_sample('{bg_level: 8'hff, edge_level: 8'hff, fill_level: 8'hff});

        // Mode three drops its samples without a pixel.
        settle_block();
        write_register(REG_EDGE_ARGB, 32'h8040_2010);
        write_register(REG_FILL_ARGB, 32'h7fc0_e0f0);
        write_register(REG_GLYPH_MODE, {30'd0, MODE_OFF});
        end_register_writes();
        send_sample('{bg_level: 8'h00, edge_level: 8'hff, fill_level: 8'h7f});
        send_sample('{bg_level: 8'h40, edge_level: 8'h01, fill_level: 8'hfe});

        // Writes past the last register go nowhere; quality zero behaves as one.
        settle_block();
        write_register(CFG_IDX_W'(REG_FILL_ARGB + 1), 32'hdead_0001);
        write_register({CFG_IDX_W{1'b1}}, 32'h0000_0003);
        write_register(REG_GLYPH_MODE, {30'd0, MODE_SUPERSAMPLE});
        write_register(REG_QUALITY, 32'd0);
        end_register_writes();
        send_sample('{bg_level: 8'h00, edge_level: 8'hc0, fill_level: 8'h33});
        send_sample('{bg_level: 8'h7e, edge_level: 8'h00, fill_level: 8'hff});

        // Quality two: a partial cell that a quality write discards, then one full cell.
        settle_block();
        write_register(REG_QUALITY, 32'd2);
        end_register_writes();
        send_sample('{bg_level: 8'h03, edge_level: 8'h10, fill_level: 8'h20});
        send_sample('{bg_level: 8'h00, edge_level: 8'h20, fill_level: 8'h40});
        send_sample('{bg_level: 8'hff, edge_level: 8'hff, fill_level: 8'hff});
        settle_block();
        write_register(REG_QUALITY, 32'd2);
        end_register_writes();
        send_sample('{bg_level: 8'h00, edge_level: 8'hff, fill_level: 8'h01});
        send_sample('{bg_level: 8'h00, edge_level: 8'hfe, fill_level: 8'h02});
        send_sample('{bg_level: 8'h00, edge_level: 8'hfd, fill_level: 8'h03});
        send_sample('{bg_level: 8'h03, edge_level: 8'hfc, fill_level: 8'h04});

        // Partial cell again, this time discarded by a mode write.
        send_sample('{bg_level: 8'hff, edge_level: 8'h00, fill_level: 8'h00});
        settle_block();
        write_register(REG_GLYPH_MODE, {30'd0, MODE_SUPERSAMPLE});
        end_register_writes();
        repeat (4) send_sample(make_sample(1'b1));

        // Random phases. The first few pin the quality extremes; after that mostly
        // small cells, well formed, with an occasional cell left open.
        counted = 0;
        round = 0;
        while (counted < RANDOM_ITEMS)
        begin
            case (round)
                0: begin mode = MODE_SUPERSAMPLE; q = 4'(MAX_QUALITY); end
                1: begin mode = MODE_SUPERSAMPLE; q = 4'hf; end
                2: begin mode = MODE_SUPERSAMPLE; q = 4'd1; end
                3: begin mode = MODE_EDGE; q = 4'd0; end
                default:
                begin
                    r = $urandom_range(0, 9);
                    mode = (r < 4) ? MODE_SUPERSAMPLE : (r < 7) ? MODE_EDGE :
                           (r < 9) ? MODE_FILL : MODE_OFF;
                    r = $urandom_range(0, 9);
                    q = 4'((r < 6) ? $urandom_range(1, 3) : (r < 8) ? $urandom_range(4, 8) :
                           (r == 8) ? 0 : $urandom_range(9, 15));
                end
            endcase
            configure(mode, q, pick_color(), pick_color());
            if (mode == MODE_SUPERSAMPLE)
            begin
                n = sb.cell_size();
                cells = (n >= 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
                repeat (cells)
                begin
                    clear_bg = 1'($urandom_range(0, 1));
                    repeat (n)
                    begin
                        send_sample(make_sample(clear_bg));
                        counted++;
                    end
                end
                // Leave a cell open; the next phase's register writes discard it.
                if (n > 1 && $urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, n - 1))
                    begin
                        send_sample(make_sample(1'($urandom_range(0, 1))));
                        counted++;
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(8, 40))
                begin
                    send_sample(make_sample($urandom_range(0, 2) == 0));
                    if (mode != MODE_OFF)
                        counted++;
                end
            end
            round++;
        end

        // Drain: every owed pixel must arrive, and nothing extra may follow.
        settle_block();
        if (sb.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
